// ===== rtl/smsp_pkg.sv =====
// ----------------------------------------------------------------------------
// smsp_pkg
// Shared types, codes and sizes of the staged motion sequence player.
// ----------------------------------------------------------------------------
package smsp_pkg;

	// sizes
	localparam int SEQ_SLOTS = 16;
	localparam int STEP_BITS = 8;
	localparam int DESC_BITS = 8;
	localparam int SLOT_BITS = (SEQ_SLOTS > 1) ? $clog2(SEQ_SLOTS) : 1;
	localparam int CMP_BITS  = (STEP_BITS > DESC_BITS) ? STEP_BITS : DESC_BITS;
	localparam logic [STEP_BITS-1:0] STEP_MAX = {STEP_BITS{1'b1}};

	// item operation codes
	typedef enum logic [1:0] {
		OP_TICK   = 2'd0,
		OP_SELECT = 2'd1,
		OP_WRITE  = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	// sequence ids
	localparam logic [3:0] SEQ_NONE       = 4'd0;
	localparam logic [3:0] SEQ_UP         = 4'd2;
	localparam logic [3:0] SEQ_DOWN       = 4'd3;
	localparam logic [3:0] SEQ_LAST_VALID = 4'd11;

	// stage of the playing sequence
	typedef enum logic [1:0] {
		ST_PREPARE  = 2'd0,
		ST_MAIN     = 2'd1,
		ST_FINALIZE = 2'd2
	} stage_t;

	// step counter operations
	typedef enum logic [2:0] {
		CNT_HOLD,
		CNT_INC,
		CNT_LOAD_MAIN,
		CNT_LOAD_FIN,
		CNT_CLEAR
	} cnt_op_t;

	// one descriptor table entry
	typedef struct packed {
		logic [DESC_BITS-1:0] main_begin;
		logic [DESC_BITS-1:0] finalize_begin;
		logic [DESC_BITS-1:0] total_steps;
		logic                 looped;
	} desc_t;

	// controller to datapath
	typedef struct packed {
		logic    sel;
		logic    wr;
		cnt_op_t cnt_op;
		logic    stage_we;
		stage_t  stage_d;
		logic    finish;
		logic    change;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic           fault;
		logic           seq_differs;
		logic           pend_none;
		stage_t         stage;
		logic           looped;
		logic           inc_ge_main;
		logic           inc_ge_fin;
		logic           inc_ge_total;
		logic           fin_ge_total;
		logic [7:0]     step8;
	} status_t;

endpackage

// ===== rtl/smsp_dpath.sv =====
// ----------------------------------------------------------------------------
// smsp_dpath
// Step counter, stage, sequence and posture registers, sticky fault and the
// descriptor table; executes controller commands and reports compare results.
// ----------------------------------------------------------------------------
module smsp_dpath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  smsp_pkg::cmd_t                        cmd,
	input  logic [3:0]                            sequence_id,
	input  logic [smsp_pkg::DESC_BITS-1:0]        main_begin,
	input  logic [smsp_pkg::DESC_BITS-1:0]        finalize_begin,
	input  logic [smsp_pkg::DESC_BITS-1:0]        total_steps,
	input  logic                                  looped,
	output smsp_pkg::status_t                     status,
	output logic [3:0]                            active_sequence,
	output logic                                  posture_up,
	output logic                                  fault
);

	logic [smsp_pkg::STEP_BITS-1:0] cnt_q;
	smsp_pkg::stage_t               stage_q;
	logic [3:0]                     cur_q;
	logic [3:0]                     pend_q;
	logic                           posture_q;
	logic                           fault_q;
	smsp_pkg::desc_t                table_q [smsp_pkg::SEQ_SLOTS];
	smsp_pkg::desc_t                desc_q;

	smsp_pkg::desc_t                wr_entry;
	logic [smsp_pkg::STEP_BITS-1:0] cnt_inc;
	logic [smsp_pkg::STEP_BITS-1:0] main_trunc;
	logic [smsp_pkg::STEP_BITS-1:0] fin_trunc;
	logic [smsp_pkg::CMP_BITS-1:0]  inc_ext;
	logic [smsp_pkg::CMP_BITS-1:0]  cnt_ext;
	logic                           pend_in_range;
	logic                           wr_in_range;
	logic                           wr_hits_cur;

	// slot range checks
	assign pend_in_range = 32'(pend_q) < smsp_pkg::SEQ_SLOTS;
	assign wr_in_range   = 32'(sequence_id) < smsp_pkg::SEQ_SLOTS;
	assign wr_hits_cur   = cmd.wr && wr_in_range && (sequence_id == cur_q);

	// entry carried by a descriptor write
	assign wr_entry = '{
		main_begin:     main_begin,
		finalize_begin: finalize_begin,
		total_steps:    total_steps,
		looped:         looped
	};

	// saturating increment and truncated loads
	assign cnt_inc    = (cnt_q < smsp_pkg::STEP_MAX) ? cnt_q + 1'b1 : cnt_q;
	assign main_trunc = smsp_pkg::STEP_BITS'(desc_q.main_begin);
	assign fin_trunc  = smsp_pkg::STEP_BITS'(desc_q.finalize_begin);
	assign inc_ext    = smsp_pkg::CMP_BITS'(cnt_inc);
	assign cnt_ext    = smsp_pkg::CMP_BITS'(cnt_q);

	// status toward the controller
	always_comb begin
		status.fault        = fault_q;
		status.seq_differs  = cur_q != pend_q;
		status.pend_none    = pend_q == smsp_pkg::SEQ_NONE;
		status.stage        = stage_q;
		status.looped       = desc_q.looped;
		status.inc_ge_main  = inc_ext >= smsp_pkg::CMP_BITS'(desc_q.main_begin);
		status.inc_ge_fin   = inc_ext >= smsp_pkg::CMP_BITS'(desc_q.finalize_begin);
		status.inc_ge_total = inc_ext >= smsp_pkg::CMP_BITS'(desc_q.total_steps);
		status.fin_ge_total = smsp_pkg::CMP_BITS'(fin_trunc)
			>= smsp_pkg::CMP_BITS'(desc_q.total_steps);
		status.step8        = cnt_ext[7:0];
	end

	assign active_sequence = cur_q;
	assign posture_up      = posture_q;
	assign fault           = fault_q;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			stage_q   <= smsp_pkg::ST_PREPARE;
			cur_q     <= smsp_pkg::SEQ_NONE;
			pend_q    <= smsp_pkg::SEQ_DOWN;
			posture_q <= 1'b0;
			fault_q   <= 1'b0;
		end else begin
			// step counter
			case (cmd.cnt_op)
				smsp_pkg::CNT_INC:       cnt_q <= cnt_inc;
				smsp_pkg::CNT_LOAD_MAIN: cnt_q <= main_trunc;
				smsp_pkg::CNT_LOAD_FIN:  cnt_q <= fin_trunc;
				smsp_pkg::CNT_CLEAR:     cnt_q <= '0;
				default:                 cnt_q <= cnt_q;
			endcase
			if (cmd.stage_we) begin
				stage_q <= cmd.stage_d;
			end
			// sequence change
			if (cmd.change) begin
				cur_q <= pend_q;
			end
			// main stage finished with nothing pending
			if (cmd.finish) begin
				posture_q <= cur_q != smsp_pkg::SEQ_DOWN;
				pend_q    <= smsp_pkg::SEQ_NONE;
			end
			// select request, gated by posture; an invalid id sets the fault
			if (cmd.sel) begin
				if (sequence_id > smsp_pkg::SEQ_LAST_VALID) begin
					fault_q <= 1'b1;
				end else if (sequence_id == smsp_pkg::SEQ_NONE) begin
					pend_q <= smsp_pkg::SEQ_NONE;
				end else if (sequence_id == smsp_pkg::SEQ_UP) begin
					if (!posture_q) begin
						pend_q <= sequence_id;
					end
				end else if (posture_q) begin
					pend_q <= sequence_id;
				end
			end
		end
	end

	// descriptor table, contents undefined until written; the entry of the
	// playing sequence is held in desc_q, loaded on a sequence change and
	// refreshed when its slot is rewritten
	always_ff @(posedge clk) begin
		if (cmd.wr && wr_in_range) begin
			table_q[smsp_pkg::SLOT_BITS'(sequence_id)] <= wr_entry;
		end
		if (cmd.change) begin
			desc_q <= pend_in_range ? table_q[smsp_pkg::SLOT_BITS'(pend_q)] : '0;
		end else if (wr_hits_cur) begin
			desc_q <= wr_entry;
		end
	end

endmodule

// ===== rtl/smsp_ctrl.sv =====
// ----------------------------------------------------------------------------
// smsp_ctrl
// Phase state machine and item handshake; turns each accepted item into
// datapath commands.
// ----------------------------------------------------------------------------
module smsp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        op,
	input  logic              move_complete,
	output logic              out_valid,
	input  logic              out_stall,
	input  smsp_pkg::status_t status,
	output smsp_pkg::cmd_t    cmd,
	output logic              start_move,
	output logic [2:0]        ctrl_phase
);

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_MOVE   = 3'd1,
		PH_WAIT   = 3'd2,
		PH_NEXT   = 3'd3,
		PH_CHANGE = 3'd4
	} phase_t;

	phase_t phase_q;
	phase_t phase_d;
	logic   out_valid_q;
	logic   pulse_q;
	logic   pulse_d;
	logic   accept;
	logic   enter_main;
	logic   main_end;

	// input waits only while a result is held and stalled
	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	// end of main stage, with the counter already advanced
	assign enter_main = (status.stage == smsp_pkg::ST_PREPARE) && status.inc_ge_main;
	assign main_end   = ((status.stage == smsp_pkg::ST_MAIN) || enter_main)
		&& status.inc_ge_fin;

	// command decode and next phase
	always_comb begin
		cmd          = '0;
		cmd.cnt_op   = smsp_pkg::CNT_HOLD;
		cmd.stage_d  = smsp_pkg::ST_PREPARE;
		phase_d      = phase_q;
		pulse_d      = 1'b0;
		if (accept) begin
			case (smsp_pkg::op_t'(op))
				smsp_pkg::OP_TICK: begin
					if (!status.fault) begin
						case (phase_q)
							PH_IDLE: begin
								if (status.seq_differs) begin
									phase_d = PH_CHANGE;
								end
							end
							PH_MOVE: begin
								pulse_d = 1'b1;
								phase_d = PH_WAIT;
							end
							PH_WAIT: begin
								if (move_complete) begin
									phase_d = PH_NEXT;
								end
							end
							PH_NEXT: begin
								phase_d    = PH_MOVE;
								cmd.cnt_op = smsp_pkg::CNT_INC;
								if (enter_main) begin
									cmd.stage_we = 1'b1;
									cmd.stage_d  = smsp_pkg::ST_MAIN;
								end
								if (main_end) begin
									if (status.seq_differs) begin
										// jump to finalize
										cmd.cnt_op   = smsp_pkg::CNT_LOAD_FIN;
										cmd.stage_we = 1'b1;
										cmd.stage_d  = smsp_pkg::ST_FINALIZE;
										if (status.fin_ge_total) begin
											phase_d = PH_CHANGE;
										end
									end else if (status.looped) begin
										cmd.cnt_op = smsp_pkg::CNT_LOAD_MAIN;
									end else begin
										// sequence done, record posture
										cmd.finish = 1'b1;
										phase_d    = PH_CHANGE;
									end
								end
								if ((status.stage == smsp_pkg::ST_FINALIZE)
									&& status.inc_ge_total) begin
									phase_d = PH_CHANGE;
								end
							end
							PH_CHANGE: begin
								cmd.change   = 1'b1;
								cmd.cnt_op   = smsp_pkg::CNT_CLEAR;
								cmd.stage_we = 1'b1;
								cmd.stage_d  = smsp_pkg::ST_PREPARE;
								phase_d      = status.pend_none ? PH_IDLE : PH_MOVE;
							end
							default: begin
								phase_d = PH_IDLE;
							end
						endcase
					end
				end
				smsp_pkg::OP_SELECT: cmd.sel = 1'b1;
				smsp_pkg::OP_WRITE:  cmd.wr  = 1'b1;
				default: ;
			endcase
		end
	end

	// phase and registered result flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			out_valid_q <= 1'b0;
			pulse_q     <= 1'b0;
		end else begin
			phase_q <= phase_d;
			if (accept) begin
				out_valid_q <= 1'b1;
				pulse_q     <= pulse_d;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign start_move = pulse_q;
	assign ctrl_phase = phase_q;

endmodule

// ===== rtl/staged_motion_sequence_player_core.sv =====
// ----------------------------------------------------------------------------
// staged_motion_sequence_player_core
// Steps through prepare, main and finalize stages of motion sequences whose
// descriptors sit in a small table.
// ----------------------------------------------------------------------------
// Usage
// - input channel (in_valid / in_stall) carries one item: a tick, a sequence
//   select or a descriptor write, chosen by op
// - output channel (out_valid / out_stall) returns one result per item: the
//   start pulse with its step index, and the state after that item
// - the result of an item is valid the cycle after it is accepted
// - throughput: one item per cycle while the output is not stalled; each
//   item is finished in the cycle it is accepted, through the phase
//   machine and the held descriptor of the playing sequence
// - the result sits in an output register; while it is stalled, in_stall is
//   raised and no new item is taken, so the state shown holds steady
// - reset: idle phase, no sequence playing, down sequence pending, posture
//   down, fault clear; the descriptor table is not cleared and an entry must
//   be written before its sequence plays
// - an invalid sequence id sets a sticky fault that freezes ticks until reset
// ----------------------------------------------------------------------------
module staged_motion_sequence_player_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     op,
	input  logic                           move_complete,
	input  logic [3:0]                     sequence_id,
	input  logic [smsp_pkg::DESC_BITS-1:0] main_begin,
	input  logic [smsp_pkg::DESC_BITS-1:0] finalize_begin,
	input  logic [smsp_pkg::DESC_BITS-1:0] total_steps,
	input  logic                           looped,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           start_move,
	output logic [7:0]                     step_index,
	output logic [3:0]                     active_sequence,
	output logic                           posture_up,
	output logic [2:0]                     ctrl_phase,
	output logic                           fault
);

	smsp_pkg::cmd_t    cmd;
	smsp_pkg::status_t status;

	// phase controller
	smsp_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.op            (op),
		.move_complete (move_complete),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.cmd           (cmd),
		.start_move    (start_move),
		.ctrl_phase    (ctrl_phase)
	);

	// counters, sequence state and descriptor table
	smsp_dpath u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sequence_id     (sequence_id),
		.main_begin      (main_begin),
		.finalize_begin  (finalize_begin),
		.total_steps     (total_steps),
		.looped          (looped),
		.status          (status),
		.active_sequence (active_sequence),
		.posture_up      (posture_up),
		.fault           (fault)
	);

	// step index shows only with the start pulse
	assign step_index = start_move ? status.step8 : 8'd0;

endmodule

// ===== tb/staged_motion_sequence_player_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// staged_motion_sequence_player_core_test
// Self-checking bench for the staged motion sequence player. It loads the
// descriptor table, walks the select rules and the counter limit, then runs
// random ticks, selects and table writes under several idle mixes and one long
// output hold. It finishes with the sticky fault. A built-in player model
// predicts the status result of every item, and each result is compared
// field by field.
// ----------------------------------------------------------------------------
module staged_motion_sequence_player_core_test;

	localparam int LIMIT_CYCLES = 400000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 8;

	// sequence ids and table layout used by the stimulus
	localparam logic [3:0] SEQ_HEIGHT       = 4'd1;
	localparam logic [3:0] SEQ_FIRST_MOTION = 4'd4;
	localparam logic [3:0] SEQ_FIRST_LOOPED = 4'd8;

	// controller phases as shown on ctrl_phase
	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_MOVE   = 3'd1,
		PH_WAIT   = 3'd2,
		PH_NEXT   = 3'd3,
		PH_CHANGE = 3'd4
	} phase_t;

	// status returned for one item
	typedef struct packed {
		logic       start;
		logic [7:0] step_idx;
		logic [3:0] seq;
		logic       up;
		logic [2:0] ph;
		logic       flt;
	} status_view_t;

	logic                           clk;
	logic                           arst_n;
	logic                           in_valid;
	logic                           in_stall;
	logic [1:0]                     op;
	logic                           move_complete;
	logic [3:0]                     sequence_id;
	logic [smsp_pkg::DESC_BITS-1:0] main_begin;
	logic [smsp_pkg::DESC_BITS-1:0] finalize_begin;
	logic [smsp_pkg::DESC_BITS-1:0] total_steps;
	logic                           looped;
	logic                           out_valid;
	logic                           out_stall;
	logic                           start_move;
	logic [7:0]                     step_index;
	logic [3:0]                     active_sequence;
	logic                           posture_up;
	logic [2:0]                     ctrl_phase;
	logic                           fault;

	staged_motion_sequence_player_core uut (.*);

	// player model state
	phase_t                         p_phase = PH_IDLE;
	smsp_pkg::stage_t               p_stage = smsp_pkg::ST_PREPARE;
	logic [smsp_pkg::STEP_BITS-1:0] p_step  = '0;
	logic [3:0]                     p_cur   = smsp_pkg::SEQ_NONE;
	logic [3:0]                     p_pend  = smsp_pkg::SEQ_DOWN;
	logic                           p_up    = 1'b0;
	logic                           p_fault = 1'b0;
	smsp_pkg::desc_t                p_table [smsp_pkg::SEQ_SLOTS];

	status_view_t status_q [$];

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	bit hold_request   = 1'b0;
	int n_errors       = 0;
	int n_items        = 0;
	int n_pulses       = 0;
	int n_finished     = 0;
	int n_at_limit     = 0;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// advance the player model by one item and report the status after it
	task automatic play_item(input smsp_pkg::op_t o, input logic done,
			input logic [3:0] id, input smsp_pkg::desc_t wr, output status_view_t v);
		smsp_pkg::desc_t d;
		logic            pulse;
		pulse = 1'b0;
		if (int'(p_cur) < smsp_pkg::SEQ_SLOTS) d = p_table[p_cur];
		else d = '0;
		case (o)
			smsp_pkg::OP_TICK: if (!p_fault) begin
				case (p_phase)
					PH_IDLE: if (p_cur != p_pend) p_phase = PH_CHANGE;
					PH_MOVE: begin
						pulse   = 1'b1;
						p_phase = PH_WAIT;
					end
					PH_WAIT: if (done) p_phase = PH_NEXT;
					PH_NEXT: begin
						if (p_step < smsp_pkg::STEP_MAX) p_step++;
						p_phase = PH_MOVE;
						if (p_stage == smsp_pkg::ST_PREPARE && p_step >= d.main_begin)
							p_stage = smsp_pkg::ST_MAIN;
						// end of the main stage: finalize, loop or finish
						if (p_stage == smsp_pkg::ST_MAIN && p_step >= d.finalize_begin) begin
							if (p_cur != p_pend) begin
								p_step  = smsp_pkg::STEP_BITS'(d.finalize_begin);
								p_stage = smsp_pkg::ST_FINALIZE;
							end else if (d.looped) begin
								p_step = smsp_pkg::STEP_BITS'(d.main_begin);
							end else begin
								p_up    = (p_cur != smsp_pkg::SEQ_DOWN);
								p_pend  = smsp_pkg::SEQ_NONE;
								p_phase = PH_CHANGE;
								n_finished++;
							end
						end
						if (p_stage == smsp_pkg::ST_FINALIZE && p_step >= d.total_steps)
							p_phase = PH_CHANGE;
					end
					PH_CHANGE: begin
						p_cur   = p_pend;
						p_step  = '0;
						p_stage = smsp_pkg::ST_PREPARE;
						if (p_cur == smsp_pkg::SEQ_NONE) p_phase = PH_IDLE;
						else p_phase = PH_MOVE;
					end
					default: p_phase = PH_IDLE;
				endcase
			end
			smsp_pkg::OP_SELECT: begin
				// posture gates the request, bad ids latch the fault
				if (id > smsp_pkg::SEQ_LAST_VALID) p_fault = 1'b1;
				else if (id == smsp_pkg::SEQ_NONE) p_pend = smsp_pkg::SEQ_NONE;
				else if (id == smsp_pkg::SEQ_UP) begin
					if (!p_up) p_pend = id;
				end else if (p_up) p_pend = id;
			end
			smsp_pkg::OP_WRITE: if (int'(id) < smsp_pkg::SEQ_SLOTS) p_table[id] = wr;
			default: ;
		endcase
		if (pulse) n_pulses++;
		if (pulse && p_step == smsp_pkg::STEP_MAX) n_at_limit++;
		v.start    = pulse;
		v.step_idx = pulse ? 8'(p_step) : 8'd0;
		v.seq      = p_cur;
		v.up       = p_up;
		v.ph       = p_phase;
		v.flt      = p_fault;
	endtask

	// offer one item, wait for it to be taken, then predict its status
	task automatic send_item(input smsp_pkg::op_t o, input logic done,
			input logic [3:0] id, input smsp_pkg::desc_t wr);
		status_view_t v;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid       <= 1'b1;
		op             <= o;
		move_complete  <= done;
		sequence_id    <= id;
		main_begin     <= wr.main_begin;
		finalize_begin <= wr.finalize_begin;
		total_steps    <= wr.total_steps;
		looped         <= wr.looped;
		@(posedge clk);
		while (in_stall !== 1'b0) @(posedge clk);
		play_item(o, done, id, wr, v);
		status_q.push_back(v);
		n_items++;
	endtask

	// descriptor with short stages so sequences keep moving, or any value
	function automatic smsp_pkg::desc_t rand_desc(input bit wide);
		smsp_pkg::desc_t d;
		if (wide) begin
			d.main_begin     = 8'($urandom);
			d.finalize_begin = 8'($urandom);
			d.total_steps    = 8'($urandom);
		end else begin
			d.main_begin     = 8'($urandom_range(0, 3));
			d.finalize_begin = 8'($urandom_range(0, 6));
			d.total_steps    = 8'($urandom_range(0, 9));
		end
		d.looped = 1'($urandom);
		return d;
	endfunction

	task automatic tick(input logic done);
		send_item(smsp_pkg::OP_TICK, done, 4'($urandom), rand_desc(1'b1));
	endtask

	task automatic select_seq(input logic [3:0] id);
		send_item(smsp_pkg::OP_SELECT, 1'($urandom), id, rand_desc(1'b1));
	endtask

	task automatic write_slot(input logic [3:0] id, input smsp_pkg::desc_t d);
		send_item(smsp_pkg::OP_WRITE, 1'($urandom), id, d);
	endtask

	// tick until the player rests with nothing pending
	task automatic run_until_idle;
		int guard;
		guard = 0;
		while (!(p_phase == PH_IDLE && p_cur == p_pend) && guard < 4000) begin
			tick($urandom_range(0, 3) != 0);
			guard++;
		end
	endtask

	// random traffic: mostly ticks, with selects, table writes and unused ops
	task automatic run_random(input int n, input int idle_pct, input int stall_pct,
			input bit with_invalid);
		int         kind;
		logic [3:0] id;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		for (int i = 0; i < n; i++) begin
			kind = $urandom_range(0, 99);
			if (kind < 68) tick($urandom_range(0, 4) != 0);
			else if (kind < 84) begin
				if (with_invalid && $urandom_range(0, 3) == 0)
					id = smsp_pkg::SEQ_LAST_VALID + 4'($urandom_range(1, 4));
				else if ($urandom_range(0, 1) == 0)
					id = 4'($urandom_range(0, smsp_pkg::SEQ_LAST_VALID));
				else if (!p_up) id = smsp_pkg::SEQ_UP;
				else begin
					id = 4'($urandom_range(SEQ_HEIGHT, smsp_pkg::SEQ_LAST_VALID));
					if (id == smsp_pkg::SEQ_UP) id = smsp_pkg::SEQ_DOWN;
				end
				select_seq(id);
			end else if (kind < 95) begin
				id = 4'($urandom);
				write_slot(id, rand_desc(id > smsp_pkg::SEQ_LAST_VALID));
			end else
				send_item(smsp_pkg::OP_NONE, 1'($urandom), 4'($urandom), rand_desc(1'b1));
		end
	endtask

	// every slot written before any sequence can read it
	task automatic test_table_load;
		smsp_pkg::desc_t d;
		for (int s = 0; s <= smsp_pkg::SEQ_LAST_VALID; s++) begin
			d        = rand_desc(1'b0);
			d.looped = (4'(s) >= SEQ_FIRST_LOOPED);
			write_slot(4'(s), d);
		end
		// slots that can never play carry extreme and alternating-bit values
		write_slot(smsp_pkg::SEQ_LAST_VALID + 4'd1, '1);
		write_slot(smsp_pkg::SEQ_LAST_VALID + 4'd2, '0);
		write_slot(smsp_pkg::SEQ_LAST_VALID + 4'd3, {8'h55, 8'haa, 8'h55, 1'b0});
		write_slot(smsp_pkg::SEQ_LAST_VALID + 4'd4, {8'haa, 8'h55, 8'haa, 1'b1});
	endtask

	// posture rules, unused op, finish, loop left through finalize
	task automatic test_select_rules;
		send_item(smsp_pkg::OP_NONE, 1'b1, 4'hf, '1);
		select_seq(SEQ_HEIGHT);
		select_seq(smsp_pkg::SEQ_DOWN);
		select_seq(smsp_pkg::SEQ_NONE);
		tick(1'b0);
		tick(1'b1);
		select_seq(smsp_pkg::SEQ_UP);
		run_until_idle();
		select_seq(smsp_pkg::SEQ_UP);
		select_seq(SEQ_FIRST_MOTION);
		run_until_idle();
		select_seq(SEQ_FIRST_LOOPED);
		repeat (20) tick(1'b1);
		select_seq(SEQ_FIRST_MOTION + 4'd1);
		run_until_idle();
		select_seq(smsp_pkg::SEQ_DOWN);
		run_until_idle();
	endtask

	// drive the step counter into its limit by rewriting a looping slot
	task automatic test_counter_limit;
		smsp_pkg::desc_t d;
		if (!p_up) begin
			select_seq(smsp_pkg::SEQ_UP);
			run_until_idle();
		end
		d        = '0;
		d.looped = 1'b1;
		write_slot(smsp_pkg::SEQ_LAST_VALID, d);
		select_seq(smsp_pkg::SEQ_LAST_VALID);
		while (!(p_cur == smsp_pkg::SEQ_LAST_VALID && p_stage == smsp_pkg::ST_MAIN))
			tick(1'b1);
		d.main_begin = smsp_pkg::STEP_MAX;
		write_slot(smsp_pkg::SEQ_LAST_VALID, d);
		repeat (12) tick(1'b1);
		select_seq(smsp_pkg::SEQ_NONE);
		run_until_idle();
		write_slot(smsp_pkg::SEQ_LAST_VALID, rand_desc(1'b0));
	endtask

	task automatic test_random_mix;
		run_random(220, 0, 0, 1'b0);
		run_random(220, 51, 0, 1'b0);
		run_random(220, 0, 51, 1'b0);
		run_random(220, 24, 24, 1'b0);
	endtask

	// output held off while items keep coming
	task automatic test_long_hold;
		hold_request = 1'b1;
		run_random(130, 0, 0, 1'b0);
	endtask

	// fault is sticky, so this runs last
	task automatic test_fault_freeze;
		recv_stall_pct = 24;
		send_idle_pct  = 24;
		select_seq(smsp_pkg::SEQ_LAST_VALID + 4'($urandom_range(1, 4)));
		run_random(60, 24, 24, 1'b1);
	endtask

	// receiver: random stall, or one long hold counted here
	initial begin : recv_side
		int hold_left;
		hold_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left != 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = HOLD_CYCLES;
				out_stall    <= 1'b1;
			end else
				out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	function automatic void check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
			n_errors++;
		end
	endfunction

	// compare each taken result with the oldest prediction
	always @(posedge clk) begin : check_results
		status_view_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (status_q.size() == 0) begin
				$display("%0t: result with no item outstanding", $time);
				n_errors++;
			end else begin
				want = status_q.pop_front();
				check_field("start_move", 8'(want.start), 8'(start_move));
				check_field("step_index", want.step_idx, step_index);
				check_field("active_sequence", 8'(want.seq), 8'(active_sequence));
				check_field("posture_up", 8'(want.up), 8'(posture_up));
				check_field("ctrl_phase", 8'(want.ph), 8'(ctrl_phase));
				check_field("fault", 8'(want.flt), 8'(fault));
			end
		end
	end

	// run limit
	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("%0t: cycle limit reached, %0d results outstanding", $time, status_q.size());
		$display("FAIL staged_motion_sequence_player_core");
		$finish;
	end

	// test sequence
	initial begin
		arst_n         <= 1'b0;
		in_valid       <= 1'b0;
		op             <= smsp_pkg::OP_TICK;
		move_complete  <= 1'b0;
		sequence_id    <= '0;
		main_begin     <= '0;
		finalize_begin <= '0;
		total_steps    <= '0;
		looped         <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		test_table_load();
		test_select_rules();
		test_counter_limit();
		test_random_mix();
		test_long_hold();
		test_fault_freeze();
		in_valid <= 1'b0;
		while (status_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d items: %0d start pulses, %0d sequences played out, %0d at step limit",
			n_items, n_pulses, n_finished, n_at_limit);
		$display("traffic: free flow, idle sender, stalling receiver, both, long hold, fault freeze");
		if (n_errors == 0) $display("PASS staged_motion_sequence_player_core");
		else $display("FAIL staged_motion_sequence_player_core");
		$finish;
	end

endmodule
